### rtl/lis_pkg.sv
// Shared types and constants for the longest increasing subsequence length core.
// Holds the beat structs, the cell link struct and the default parameter values.
// No dependencies.
`default_nettype none

package lis_pkg;

   localparam int DEF_MAX_LEN     = 64;
   localparam int DEF_VALUE_BITS  = 32;
   localparam int VALUE_FIELD_BITS = 32;
   localparam int LENGTH_BITS     = 7;

   typedef struct packed {
      logic signed [VALUE_FIELD_BITS-1:0] value;
      logic                               last;
   } req_beat_type;

   typedef struct packed {
      logic [LENGTH_BITS-1:0] length;
      logic                   overflow;
   } rsp_beat_type;

   // Status handed from one cell to the next one up the chain.
   typedef struct packed {
      logic valid;
      logic hit;
   } cell_link_type;

endpackage

`default_nettype wire

### rtl/lis_length_stream_core.sv
// Top level of the longest strictly increasing subsequence length core.
// Depends on lis_pkg and instantiates a chain of lis_cell tail cells.
//
// The core takes one value beat per clock cycle and answers each beat that
// carries last with one result beat holding the subsequence length and an
// overflow flag. Every cell compares the incoming value against its own tail
// in the same cycle and passes a one-bit hit to its neighbor, and the state is
// cleared on the cycle that takes the last beat. A last beat is held off only
// while the previous result still sits stalled in the output register; other
// beats are never held.
`default_nettype none

module lis_length_stream_core #(
   parameter int MAX_LEN    = lis_pkg::DEF_MAX_LEN,
   parameter int VALUE_BITS = lis_pkg::DEF_VALUE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire lis_pkg::req_beat_type  req_beat,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output lis_pkg::rsp_beat_type       rsp_beat
);
   import lis_pkg::*;

   localparam int LEN_W = $clog2(MAX_LEN + 1);

   logic                  take;
   logic                  flush;
   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] key;
   cell_link_type         links [MAX_LEN+1];

   logic [LEN_W-1:0]      run_length_ff;
   logic [LEN_W-1:0]      run_length_in;
   logic [LEN_W-1:0]      length_next;
   logic                  overflowed_ff;
   logic                  overflowed_in;
   logic                  overflow_next;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_beat_type          rsp_ff;
   rsp_beat_type          rsp_in;

   assign req_stall = req_beat.last && rsp_valid_ff && rsp_stall;
   assign take = req_valid && !req_stall;
   assign flush = take && req_beat.last;

   assign raw = VALUE_BITS'($unsigned(req_beat.value));
   assign key = {~raw[VALUE_BITS-1], raw[VALUE_BITS-2:0]};

   assign links[0] = '{valid: 1'b1, hit: 1'b0};

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      lis_cell #(
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .take    (take),
         .flush   (flush),
         .key     (key),
         .link_in (links[i]),
         .link_out(links[i+1])
      );
   end

   always_comb begin
      length_next = run_length_ff;
      overflow_next = overflowed_ff;
      if (!links[MAX_LEN].hit) begin
         if (links[MAX_LEN].valid) begin
            overflow_next = 1'b1;
         end else begin
            length_next = LEN_W'(run_length_ff + 1'b1);
         end
      end

      if (flush) begin
         run_length_in = '0;
         overflowed_in = 1'b0;
      end else if (take) begin
         run_length_in = length_next;
         overflowed_in = overflow_next;
      end else begin
         run_length_in = run_length_ff;
         overflowed_in = overflowed_ff;
      end

      if (flush) begin
         rsp_valid_in = 1'b1;
         rsp_in.length = LENGTH_BITS'(length_next);
         rsp_in.overflow = overflow_next;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_length_ff <= '0;
         overflowed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_length_ff <= run_length_in;
         overflowed_ff <= overflowed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat = rsp_ff;

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      run_length_ff <= LEN_W'(MAX_LEN))
      else $error("tail count exceeds the store size");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      flush |=> (run_length_ff == '0) && !overflowed_ff)
      else $error("state not cleared after the last beat");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflowed_ff |-> (run_length_ff == LEN_W'(MAX_LEN)))
      else $error("overflow set while the tail store is not full");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(flush))
      else $error("result beat without a last input beat");

endmodule

`default_nettype wire

### rtl/lis_cell.sv
// One tail cell of the chain: holds one tail key and its valid bit.
// Depends on lis_pkg for the link struct passed between neighboring cells.
`default_nettype none

module lis_cell #(
   parameter int VALUE_BITS = lis_pkg::DEF_VALUE_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    take,
   input  wire logic                    flush,
   input  wire logic [VALUE_BITS-1:0]   key,
   input  wire lis_pkg::cell_link_type  link_in,
   output lis_pkg::cell_link_type       link_out
);
   import lis_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [VALUE_BITS-1:0] tail_ff;
   logic [VALUE_BITS-1:0] tail_in;
   logic                  ge;
   logic                  write;

   always_comb begin
      ge = valid_ff && (tail_ff >= key);
      write = take && link_in.valid && !link_in.hit && (!valid_ff || ge);
      if (flush) begin
         valid_in = 1'b0;
      end else if (write) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff;
      end
      tail_in = write ? key : tail_ff;
      link_out.valid = valid_ff;
      link_out.hit = link_in.hit | ge;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire
